FILE: hw/rtl/ntrf_pkg.sv
package ntrf_pkg;

    // Record header flag bits
    localparam logic [7:0] FLAG_ME        = 8'h40;
    localparam logic [7:0] FLAG_SR        = 8'h10;
    localparam logic [7:0] FLAG_IL        = 8'h08;
    localparam logic [7:0] TNF_MASK       = 8'h07;
    localparam logic [7:0] TNF_WELL_KNOWN = 8'h01;
    localparam logic [7:0] TEXT_TYPE      = 8'h54;  // 'T'

    // Short payload length takes one byte, long takes four
    localparam logic [31:0] PLEN_SHORT = 32'd1;
    localparam logic [31:0] PLEN_LONG  = 32'd4;

    // One search result
    typedef struct packed {
        logic        found;
        logic [15:0] offset;
        logic [15:0] size;
    } t_result;

endpackage

FILE: hw/rtl/ntrf_parse.sv
module ntrf_parse import ntrf_pkg::*; #(
    parameter int POS_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_req,
    input  logic [15:0] i_msg_length,
    output logic        o_res_valid,
    output t_result     o_res
);

    localparam int PW = POS_BITS + 1;
    localparam int BW = ((PW > 34) ? PW : 34) + 1;

    typedef enum logic [2:0] {
        PH_FLAGS,
        PH_TYPELEN,
        PH_PLEN,
        PH_ID,
        PH_TYPE,
        PH_SKIP
    } t_phase;

    t_phase              r_phase, c_phase, n_phase;
    logic [POS_BITS-1:0] r_pos, c_pos, n_pos;
    logic [POS_BITS-1:0] r_len, c_len, n_len;
    logic [7:0]          r_flags, c_flags, n_flags;
    logic [7:0]          r_tl, c_tl, n_tl;
    logic [7:0]          r_il, c_il, n_il;
    logic [31:0]         r_pl, c_pl, n_pl;
    logic [31:0]         r_skip, c_skip, n_skip;
    logic                r_decided, c_decided, n_decided;

    logic          start;
    logic [PW-1:0] p;
    logic [BW-1:0] p_x, len_x;
    logic [31:0]   pl_shift, hd_pl, skip_dec, plen_left;
    logic [7:0]    hd_il;
    logic [BW-1:0] body, total, rest, rest_end, text_off;
    logic          hd_text;

    always_comb begin
        // A start byte clears the parser state and loads a new length
        start     = i_valid && i_start_req;
        c_phase   = start ? PH_FLAGS : r_phase;
        c_pos     = start ? '0 : r_pos;
        c_len     = start ? POS_BITS'(i_msg_length) : r_len;
        c_flags   = start ? '0 : r_flags;
        c_tl      = start ? '0 : r_tl;
        c_il      = start ? '0 : r_il;
        c_pl      = start ? '0 : r_pl;
        c_skip    = start ? '0 : r_skip;
        c_decided = start ? 1'b0 : r_decided;

        // Position arithmetic, wide enough never to wrap
        p        = PW'(c_pos) + PW'(1);
        p_x      = BW'(p);
        len_x    = BW'(c_len);
        pl_shift = {c_pl[23:0], i_data_byte};
        hd_pl    = (c_phase == PH_ID) ? c_pl : pl_shift;
        hd_il    = (c_phase == PH_ID) ? i_data_byte : c_il;
        body     = BW'(c_tl) + BW'(hd_il) + BW'(hd_pl);
        total    = p_x + body;
        rest     = BW'(c_il) + BW'(c_pl);
        rest_end = p_x + rest;
        text_off = p_x + BW'(c_il);
        hd_text  = ((c_flags & TNF_MASK) == TNF_WELL_KNOWN) && (c_tl == 8'd1);
        skip_dec = (c_skip != '0) ? c_skip - 32'd1 : c_skip;
        plen_left = c_skip - 32'd1;

        n_phase   = c_phase;
        n_pos     = c_pos;
        n_len     = c_len;
        n_flags   = c_flags;
        n_tl      = c_tl;
        n_il      = c_il;
        n_pl      = c_pl;
        n_skip    = c_skip;
        n_decided = c_decided;

        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_valid) begin
            if (start && (c_len == '0)) begin
                // Empty message: not found at once
                o_res_valid = 1'b1;
            end else if (!c_decided) begin
                n_pos = c_pos + POS_BITS'(1);
                unique case (c_phase)
                    PH_FLAGS: begin
                        n_flags = i_data_byte;
                        n_tl    = '0;
                        n_il    = '0;
                        n_pl    = '0;
                        if (BW'(p) >= len_x) o_res_valid = 1'b1;
                        else                 n_phase = PH_TYPELEN;
                    end
                    PH_TYPELEN: begin
                        n_tl = i_data_byte;
                        if ((c_flags & FLAG_SR) != '0) begin
                            if (p_x >= len_x) o_res_valid = 1'b1;
                            else begin
                                n_skip  = PLEN_SHORT;
                                n_phase = PH_PLEN;
                            end
                        end else begin
                            if (p_x + BW'(4) > len_x) o_res_valid = 1'b1;
                            else begin
                                n_skip  = PLEN_LONG;
                                n_phase = PH_PLEN;
                            end
                        end
                    end
                    PH_PLEN, PH_ID: begin
                        if (c_phase == PH_PLEN) begin
                            n_pl   = pl_shift;
                            n_skip = plen_left;
                        end else begin
                            n_il = i_data_byte;
                        end
                        if ((c_phase == PH_PLEN) && (plen_left != '0)) begin
                            // more length bytes to come
                        end else if ((c_phase == PH_PLEN) &&
                                     ((c_flags & FLAG_IL) != '0)) begin
                            if (p_x >= len_x) o_res_valid = 1'b1;
                            else              n_phase = PH_ID;
                        end else begin
                            // Header complete: bound check, then type, skip, next record or a not-found result
                            if (total > len_x) o_res_valid = 1'b1;
                            else if (hd_text) n_phase = PH_TYPE;
                            else if ((c_flags & FLAG_ME) != '0) o_res_valid = 1'b1;
                            else if (total >= len_x) o_res_valid = 1'b1;
                            else begin
                                n_skip  = body[31:0];
                                n_phase = (body != '0) ? PH_SKIP : PH_FLAGS;
                            end
                        end
                    end
                    PH_TYPE: begin
                        if (i_data_byte == TEXT_TYPE) begin
                            o_res_valid  = 1'b1;
                            o_res.found  = 1'b1;
                            o_res.offset = text_off[15:0];
                            o_res.size   = c_pl[15:0];
                        end else if ((c_flags & FLAG_ME) != '0) begin
                            o_res_valid = 1'b1;
                        end else if (rest_end >= len_x) begin
                            o_res_valid = 1'b1;
                        end else begin
                            n_skip  = rest[31:0];
                            n_phase = (rest != '0) ? PH_SKIP : PH_FLAGS;
                        end
                    end
                    PH_SKIP: begin
                        n_skip = skip_dec;
                        if (skip_dec == '0) n_phase = PH_FLAGS;
                    end
                    default: o_res_valid = 1'b1;
                endcase
            end
            if (o_res_valid) n_decided = 1'b1;
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_FLAGS;
            r_pos     <= '0;
            r_len     <= '0;
            r_flags   <= '0;
            r_tl      <= '0;
            r_il      <= '0;
            r_pl      <= '0;
            r_skip    <= '0;
            r_decided <= 1'b1;
        end else begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_len     <= n_len;
            r_flags   <= n_flags;
            r_tl      <= n_tl;
            r_il      <= n_il;
            r_pl      <= n_pl;
            r_skip    <= n_skip;
            r_decided <= n_decided;
        end
    end

endmodule

FILE: hw/rtl/ndef_text_record_finder.sv
// A deciding byte is registered at the input; its result is registered in the queue.
// Throughput: one byte per cycle while o_stall is low; header registers and
// counters update per byte. A two-entry result queue lets input continue while one
// result waits, unless the output stalls with a byte in flight.
// Reset (i_rst_n low, synchronous) empties the pipe and queue and leaves the
// parser idle until a byte with i_start_req set arrives.
module ndef_text_record_finder import ntrf_pkg::*; #(
    parameter int POS_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_req,
    input  logic [15:0] i_msg_length,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_found,
    output logic [15:0] o_payload_offset,
    output logic [15:0] o_payload_size
);

    logic        r_in_valid;
    logic [7:0]  r_data;
    logic        r_start;
    logic [15:0] r_len;
    logic [1:0]  r_cnt, n_cnt;
    t_result     r_q0, r_q1, n_q0, n_q1;
    logic        res_valid, push, pop, accept;
    t_result     res;

    // Stall when the queue could not absorb the byte already in flight:
    // queue full, or one result waiting that the output does not take now while a byte is in flight
    assign o_stall = (r_cnt == 2'd2) || ((r_cnt == 2'd1) && r_in_valid && i_stall);
    assign accept  = i_valid && !o_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data  <= i_data_byte;
            r_start <= i_start_req;
            r_len   <= i_msg_length;
        end
    end

    ntrf_parse #(
        .POS_BITS (POS_BITS)
    ) u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_in_valid),
        .i_data_byte  (r_data),
        .i_start_req  (r_start),
        .i_msg_length (r_len),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    // Result queue, two entries
    assign push = res_valid;
    assign pop  = (r_cnt != 2'd0) && !i_stall;

    always_comb begin
        n_cnt = r_cnt;
        n_q0  = r_q0;
        n_q1  = r_q1;
        priority if (push && pop) begin
            if (r_cnt == 2'd1) begin
                n_q0 = res;
            end else begin
                n_q0 = r_q1;
                n_q1 = res;
            end
        end else if (pop) begin
            n_q0  = r_q1;
            n_cnt = r_cnt - 2'd1;
        end else if (push) begin
            if (r_cnt == 2'd0) n_q0 = res;
            else               n_q1 = res;
            n_cnt = r_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign o_valid          = (r_cnt != 2'd0);
    assign o_found          = r_q0.found;
    assign o_payload_offset = r_q0.offset;
    assign o_payload_size   = r_q0.size;

endmodule

FILE: hw/rtl/ntrf_checker.sv
module ntrf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_found,
    input logic [15:0] o_payload_offset,
    input logic [15:0] o_payload_size
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // Not found carries zero offset and size
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> (o_payload_offset == 16'd0) && (o_payload_size == 16'd0))
        else $error("not-found result with nonzero fields");

    // A text payload starts after flags, type length, payload length and type
    a_found_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> (o_payload_offset >= 16'd4))
        else $error("found payload offset inside header");

    // Reset empties the queue and frees the input
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("queue not empty after reset");

endmodule

bind ndef_text_record_finder ntrf_checker u_ntrf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_found          (o_found),
    .o_payload_offset (o_payload_offset),
    .o_payload_size   (o_payload_size)
);
